@@ src/vec3_normalize_defines.svh @@
// Assertion macros shared by the vec3_normalize RTL.
`ifndef VEC3_NORMALIZE_DEFINES_SVH
`define VEC3_NORMALIZE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while in reset.
`define V3N_CHECK(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while in reset.
`define V3N_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/v3n_pkg.sv @@
// Types and constants of the 3D vector normalizer.
`timescale 1ns / 1ps

package v3n_pkg;

    localparam int IN_WIDTH  = 16;
    localparam int OUT_FRAC  = 14;
    localparam int MAG_FRAC  = 8;
    localparam int OUT_WIDTH = OUT_FRAC + 2;

    // Sum of three squares stays below 2^(2*IN_WIDTH).
    localparam int SUM_W     = 2 * IN_WIDTH;
    localparam int ABS_W     = IN_WIDTH;
    // Root of the sum with MAG_FRAC fraction bits, one bit per square-root cell.
    localparam int ROOT_W    = IN_WIDTH + MAG_FRAC;
    localparam int REM_W     = ROOT_W + 2;
    // Quotient is at most 2^OUT_FRAC, so OUT_FRAC+1 bits, one bit per divider cell.
    localparam int DIV_STEPS = OUT_FRAC + 1;
    localparam int DIV_PRE   = OUT_FRAC + MAG_FRAC - DIV_STEPS;
    localparam int PART_W    = ROOT_W;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] comp_x;
        logic signed [IN_WIDTH-1:0] comp_y;
        logic signed [IN_WIDTH-1:0] comp_z;
    } v3n_in_t;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] unit_x;
        logic signed [OUT_WIDTH-1:0] unit_y;
        logic signed [OUT_WIDTH-1:0] unit_z;
        logic                        zero_vector;
    } v3n_out_t;

    // Beat carried along the square-root cells.
    typedef struct packed {
        logic [2:0][ABS_W-1:0] mag_c;
        logic [2:0]            neg;
        logic                  zero;
        logic [SUM_W-1:0]      rad;
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
    } v3n_sq_t;

    // Beat carried along the divider cells.
    typedef struct packed {
        logic [ROOT_W-1:0]          mag;
        logic [2:0][PART_W-1:0]     part;
        logic [2:0][DIV_STEPS-1:0]  quot;
        logic [2:0]                 neg;
        logic                       zero;
    } v3n_dv_t;

endpackage

@@ src/v3n_sqrt_cell.sv @@
// One cell of the square-root chain: resolves one root bit per beat.
`timescale 1ns / 1ps

module v3n_sqrt_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  v3n_pkg::v3n_sq_t d_in,
    output logic             valid_out,
    output v3n_pkg::v3n_sq_t d_out
);

    logic                          valid_reg;
    v3n_pkg::v3n_sq_t              data_reg;
    v3n_pkg::v3n_sq_t              data_next;
    logic [v3n_pkg::REM_W+1:0]     rem_sh;
    logic [v3n_pkg::REM_W+1:0]     trial;
    logic                          take;

    always_comb
    begin
        // Bring down the next two radicand bits and try the next root bit.
        rem_sh = {d_in.rem, d_in.rad[v3n_pkg::SUM_W-1 -: 2]};
        trial  = (v3n_pkg::REM_W + 2)'({d_in.root, 2'b01});
        take   = (rem_sh >= trial);

        data_next      = d_in;
        data_next.rad  = {d_in.rad[v3n_pkg::SUM_W-3:0], 2'b00};
        data_next.rem  = take ? v3n_pkg::REM_W'(rem_sh - trial) : v3n_pkg::REM_W'(rem_sh);
        data_next.root = {d_in.root[v3n_pkg::ROOT_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign d_out     = data_reg;

endmodule

@@ src/v3n_div_cell.sv @@
// One cell of the divider chain: one quotient bit for each of the three lanes.
`timescale 1ns / 1ps

module v3n_div_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    input  v3n_pkg::v3n_dv_t d_in,
    output logic             valid_out,
    output v3n_pkg::v3n_dv_t d_out
);

    logic                           valid_reg;
    v3n_pkg::v3n_dv_t               data_reg;
    v3n_pkg::v3n_dv_t               data_next;
    logic [2:0][v3n_pkg::PART_W:0]  part_sh;
    logic [2:0]                     ge;

    always_comb
    begin
        data_next = d_in;
        for (int i = 0; i < 3; i++)
        begin
            // The numerator bits still to come are all zero, so only a shift.
            part_sh[i] = {d_in.part[i], 1'b0};
            ge[i]      = (part_sh[i] >= {1'b0, d_in.mag});
            data_next.part[i] = ge[i] ? v3n_pkg::PART_W'(part_sh[i] - {1'b0, d_in.mag})
                                      : v3n_pkg::PART_W'(part_sh[i]);
            data_next.quot[i] = {d_in.quot[i][v3n_pkg::DIV_STEPS-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign d_out     = data_reg;

endmodule

@@ src/vec3_normalize.sv @@
// Normalizes a 3D integer vector to a unit vector in signed Q1.14. The block
// takes one vector in every cycle and busy never rises; each result is taken
// at the clock edge 42 cycles after the edge that accepted its vector, on a
// one-cycle done strobe that the receiver must take as it comes. The latency
// is set by the chain of 42 registers, the first loaded at the accepting edge:
// one of squaring, one of summing, 24 square-root cells (one root bit each),
// 15 divider cells (one quotient bit for all three lanes each) and the output
// register. A vector of all zeros gives zero outputs with zero_vector set.
// No clearing pass or warm-up follows reset.
`timescale 1ns / 1ps
`include "vec3_normalize_defines.svh"

module vec3_normalize (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  v3n_pkg::v3n_in_t  vec,
    output logic              done,
    output v3n_pkg::v3n_out_t result
);

    localparam int SQ_CELLS = v3n_pkg::ROOT_W;
    localparam int LATENCY  = 2 + SQ_CELLS + v3n_pkg::DIV_STEPS + 1;
    localparam logic signed [v3n_pkg::OUT_WIDTH-1:0] UNIT_ONE =
        v3n_pkg::OUT_WIDTH'(1 << v3n_pkg::OUT_FRAC);
    localparam logic [v3n_pkg::DIV_STEPS-1:0] QUOT_ONE =
        v3n_pkg::DIV_STEPS'(1 << v3n_pkg::OUT_FRAC);

    // Squaring stage.
    logic                                             sa_valid_reg;
    logic [2:0][v3n_pkg::SUM_W-1:0]                   sa_sq_reg;
    logic [2:0][v3n_pkg::SUM_W-1:0]                   sa_sq_next;
    logic [2:0][v3n_pkg::ABS_W-1:0]                   sa_abs_reg;
    logic [2:0][v3n_pkg::ABS_W-1:0]                   sa_abs_next;
    logic [2:0]                                       sa_neg_reg;
    logic [2:0]                                       sa_neg_next;
    logic                                             sa_zero_reg;
    logic                                             sa_zero_next;
    logic signed [2:0][v3n_pkg::IN_WIDTH-1:0]         comp;
    logic signed [2:0][2*v3n_pkg::IN_WIDTH-1:0]       prod;

    // Square-root and divider chains.
    logic                 sq_valid [0:SQ_CELLS];
    v3n_pkg::v3n_sq_t     sq_data  [0:SQ_CELLS];
    logic                 sb_valid_reg;
    v3n_pkg::v3n_sq_t     sb_reg;
    v3n_pkg::v3n_sq_t     sb_next;
    logic                 dv_valid [0:v3n_pkg::DIV_STEPS];
    v3n_pkg::v3n_dv_t     dv_data  [0:v3n_pkg::DIV_STEPS];

    // Output stage.
    logic                                             done_reg;
    v3n_pkg::v3n_out_t                                result_reg;
    v3n_pkg::v3n_out_t                                result_next;
    logic [2:0][v3n_pkg::DIV_STEPS-1:0]               quot_sat;
    logic signed [2:0][v3n_pkg::OUT_WIDTH-1:0]        lane;

    assign busy = 1'b0;

    always_comb
    begin
        comp[0] = vec.comp_x;
        comp[1] = vec.comp_y;
        comp[2] = vec.comp_z;
        for (int i = 0; i < 3; i++)
        begin
            prod[i]        = $signed(comp[i]) * $signed(comp[i]);
            sa_sq_next[i]  = v3n_pkg::SUM_W'(prod[i]);
            sa_neg_next[i] = comp[i][v3n_pkg::IN_WIDTH-1];
            // Negating the most negative value wraps to its correct magnitude.
            sa_abs_next[i] = sa_neg_next[i] ? v3n_pkg::ABS_W'(-comp[i])
                                            : v3n_pkg::ABS_W'(comp[i]);
        end
        sa_zero_next = (comp[0] == '0) && (comp[1] == '0) && (comp[2] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            sa_valid_reg <= start && !busy;
            sb_valid_reg <= sa_valid_reg;
            done_reg     <= dv_valid[v3n_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        sa_sq_reg   <= sa_sq_next;
        sa_abs_reg  <= sa_abs_next;
        sa_neg_reg  <= sa_neg_next;
        sa_zero_reg <= sa_zero_next;
        sb_reg      <= sb_next;
        result_reg  <= result_next;
    end

    // Sum of squares seeds the square-root chain.
    always_comb
    begin
        sb_next.mag_c = sa_abs_reg;
        sb_next.neg   = sa_neg_reg;
        sb_next.zero  = sa_zero_reg;
        sb_next.rad   = sa_sq_reg[0] + sa_sq_reg[1] + sa_sq_reg[2];
        sb_next.rem   = '0;
        sb_next.root  = '0;
    end

    assign sq_valid[0] = sb_valid_reg;
    assign sq_data[0]  = sb_reg;

    for (genvar g = 0; g < SQ_CELLS; g++)
    begin : g_sqrt
        v3n_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sq_valid[g]),
            .d_in      (sq_data[g]),
            .valid_out (sq_valid[g+1]),
            .d_out     (sq_data[g+1])
        );
    end

    // The leading numerator bits go straight into the partial remainder.
    always_comb
    begin
        dv_valid[0]     = sq_valid[SQ_CELLS];
        dv_data[0].mag  = sq_data[SQ_CELLS].root;
        dv_data[0].neg  = sq_data[SQ_CELLS].neg;
        dv_data[0].zero = sq_data[SQ_CELLS].zero;
        for (int i = 0; i < 3; i++)
        begin
            dv_data[0].part[i] = v3n_pkg::PART_W'({sq_data[SQ_CELLS].mag_c[i],
                                                   {v3n_pkg::DIV_PRE{1'b0}}});
            dv_data[0].quot[i] = '0;
        end
    end

    for (genvar g = 0; g < v3n_pkg::DIV_STEPS; g++)
    begin : g_div
        v3n_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (dv_valid[g]),
            .d_in      (dv_data[g]),
            .valid_out (dv_valid[g+1]),
            .d_out     (dv_data[g+1])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            quot_sat[i] = (dv_data[v3n_pkg::DIV_STEPS].quot[i] > QUOT_ONE)
                        ? QUOT_ONE : dv_data[v3n_pkg::DIV_STEPS].quot[i];
            lane[i] = dv_data[v3n_pkg::DIV_STEPS].neg[i]
                    ? -$signed(v3n_pkg::OUT_WIDTH'(quot_sat[i]))
                    : $signed(v3n_pkg::OUT_WIDTH'(quot_sat[i]));
            if (dv_data[v3n_pkg::DIV_STEPS].zero)
            begin
                lane[i] = '0;
            end
        end
        result_next.unit_x      = lane[0];
        result_next.unit_y      = lane[1];
        result_next.unit_z      = lane[2];
        result_next.zero_vector = dv_data[v3n_pkg::DIV_STEPS].zero;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `V3N_CHECK(a_done_has_source, done, $past(start && !busy, LATENCY), "result without an accepted vector")
    `V3N_CHECK_NEXT(a_accept_enters, start && !busy, sa_valid_reg, "accepted vector lost at entry")
    `V3N_CHECK(a_mag_nonzero, sq_valid[SQ_CELLS] && !sq_data[SQ_CELLS].zero, sq_data[SQ_CELLS].root != '0, "zero magnitude for a nonzero vector")
    `V3N_CHECK(a_zero_clears, done && result.zero_vector, (result.unit_x == '0) && (result.unit_y == '0) && (result.unit_z == '0), "zero vector with nonzero outputs")
    `V3N_CHECK(a_unit_range, done, (result.unit_x <= UNIT_ONE) && (result.unit_x >= -UNIT_ONE) && (result.unit_y <= UNIT_ONE) && (result.unit_y >= -UNIT_ONE) && (result.unit_z <= UNIT_ONE) && (result.unit_z >= -UNIT_ONE), "unit component out of range")

endmodule
